### src/stack_pop_sequence_checker_defines.svh
// assertion macros shared by the stack pop sequence checker
`ifndef STACK_POP_SEQUENCE_CHECKER_DEFINES_SVH
`define STACK_POP_SEQUENCE_CHECKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SPSC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SPSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/spsc_pkg.sv
// shared types and constants of the stack pop sequence checker
package spsc_pkg;

   // configuration register widths and reset values
   localparam int CAPACITY_W      = 11;
   localparam int MAX_VALUE_W     = 10;
   localparam int CSR_DATA_W      = 11;
   localparam int CSR_INDEX_W     = 1;
   localparam int FAIL_W          = 2;

   localparam logic [CAPACITY_W-1:0]  CAPACITY_RESET  = 11'd5;
   localparam logic [MAX_VALUE_W-1:0] MAX_VALUE_RESET = 10'd7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE = 1'b1;

   // failure codes
   typedef enum logic [FAIL_W-1:0] {
      FAIL_NONE     = 2'd0,
      FAIL_CAPACITY = 2'd1,
      FAIL_NOT_TOP  = 2'd2,
      FAIL_RANGE    = 2'd3
   } fail_type;

   // controller to datapath commands
   typedef struct packed {
      logic     load_item;
      logic     set_fail;
      fail_type fail_code;
      logic     push;
      logic     set_next;
      logic     read_top;
      logic     pop;
      logic     load_rsp;
      logic     clear_seq;
   } spsc_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic prior_fail;
      logic range_bad;
      logic at_or_above;
      logic cap_bad;
      logic push_done;
      logic stack_empty;
      logic top_match;
      logic is_last;
   } spsc_status_type;

endpackage

### src/spsc_req_if.sv
// request channel: one popped value and its last flag
interface spsc_req_if #(
   parameter int VALUE_BITS = 10
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] popped_value;
   logic                  is_last;

   modport source (output valid, output popped_value, output is_last, input ready);
   modport sink   (input valid, input popped_value, input is_last, output ready);
endinterface

### src/spsc_rsp_if.sv
// response channel: verdict and first failure of a sequence
interface spsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            sequence_ok;
   logic [spsc_pkg::FAIL_W-1:0]     fail_reason;

   modport source (output valid, output sequence_ok, output fail_reason, input ready);
   modport sink   (input valid, input sequence_ok, input fail_reason, output ready);
endinterface

### src/spsc_datapath.sv
// datapath: configuration, sequence state, stack memory and result register
module spsc_datapath #(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_BITS  = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [spsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [VALUE_BITS-1:0]             item_value,
   input  logic                              item_last,
   input  spsc_pkg::spsc_cmd_type            cmd,
   output spsc_pkg::spsc_status_type         status,
   output logic                              rsp_ok,
   output logic [spsc_pkg::FAIL_W-1:0]       rsp_reason
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NP_W   = VALUE_BITS + 1;
   localparam int WIDE_W = (CNT_W > NP_W) ? CNT_W : NP_W;
   localparam int SUM_W  = ((WIDE_W > spsc_pkg::CAPACITY_W) ? WIDE_W
                                                             : spsc_pkg::CAPACITY_W) + 1;

   // configuration registers
   logic [spsc_pkg::CAPACITY_W-1:0]  capacity_ff;
   logic [spsc_pkg::MAX_VALUE_W-1:0] max_value_ff;

   // item and sequence state
   logic [VALUE_BITS-1:0] value_ff;
   logic                  last_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NP_W-1:0]       next_push_ff, next_push_in;
   spsc_pkg::fail_type    fail_ff, fail_in;

   // stack memory and registered top read
   logic [VALUE_BITS-1:0] stack_mem_ff [STACK_DEPTH];
   logic [VALUE_BITS-1:0] top_ff;

   // result register
   logic                  rsp_ok_ff;
   logic [spsc_pkg::FAIL_W-1:0] rsp_reason_ff;

   logic [CNT_W-1:0] count_m1;
   logic [SUM_W-1:0] value_x, next_x, peak, room;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= spsc_pkg::CAPACITY_RESET;
         max_value_ff <= spsc_pkg::MAX_VALUE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            spsc_pkg::CSR_CAPACITY:  capacity_ff  <= csr_wdata[spsc_pkg::CAPACITY_W-1:0];
            spsc_pkg::CSR_MAX_VALUE: max_value_ff <= csr_wdata[spsc_pkg::MAX_VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         value_ff <= item_value;
         last_ff  <= item_last;
      end
   end

   // peak fill check against the clamped capacity
   always_comb begin
      value_x = SUM_W'(value_ff);
      next_x  = SUM_W'(next_push_ff);
      peak    = SUM_W'(count_ff) + value_x - next_x + SUM_W'(1);
      room    = (SUM_W'(capacity_ff) > SUM_W'(STACK_DEPTH)) ? SUM_W'(STACK_DEPTH)
                                                              : SUM_W'(capacity_ff);
   end

   assign count_m1 = count_ff - CNT_W'(1);

   // status toward the controller
   always_comb begin
      status.prior_fail  = (fail_ff != spsc_pkg::FAIL_NONE);
      status.range_bad   = (value_ff == '0) ||
                           (value_x > SUM_W'(max_value_ff));
      status.at_or_above = (value_x >= next_x);
      status.cap_bad     = (peak > room);
      status.push_done   = (next_x == value_x);
      status.stack_empty = (count_ff == '0);
      status.top_match   = (top_ff == value_ff);
      status.is_last     = last_ff;
   end

   // next sequence state
   always_comb begin
      count_in     = count_ff;
      next_push_in = next_push_ff;
      fail_in      = fail_ff;
      if (cmd.clear_seq) begin
         count_in     = '0;
         next_push_in = NP_W'(1);
         fail_in      = spsc_pkg::FAIL_NONE;
      end else begin
         if (cmd.set_fail) begin
            fail_in = cmd.fail_code;
         end
         if (cmd.push) begin
            count_in     = count_ff + CNT_W'(1);
            next_push_in = next_push_ff + NP_W'(1);
         end
         if (cmd.pop) begin
            count_in = count_m1;
         end
         if (cmd.set_next) begin
            next_push_in = NP_W'(value_ff) + NP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_push_ff <= NP_W'(1);
         fail_ff      <= spsc_pkg::FAIL_NONE;
      end else begin
         count_ff     <= count_in;
         next_push_ff <= next_push_in;
         fail_ff      <= fail_in;
      end
   end

   // stack memory: push writes at the fill level, the top read takes the entry one below it
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem_ff[count_ff[IDX_W-1:0]] <= next_push_ff[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_top) begin
         top_ff <= stack_mem_ff[count_m1[IDX_W-1:0]];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff     <= (fail_ff == spsc_pkg::FAIL_NONE);
         rsp_reason_ff <= fail_ff;
      end
   end

   assign rsp_ok     = rsp_ok_ff;
   assign rsp_reason = rsp_reason_ff;

endmodule

### src/spsc_controller.sv
// controller: sequences judging, pushes, top check and response hand-off
module spsc_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  spsc_pkg::spsc_status_type status,
   output spsc_pkg::spsc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PUSH,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_busy;

   assign rsp_busy = rsp_valid_ff && !rsp_ready;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.fail_code = spsc_pkg::FAIL_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
            if (status.prior_fail) begin
               state_in = ST_FINISH;
            end else if (status.range_bad) begin
               cmd.set_fail  = 1'b1;
               cmd.fail_code = spsc_pkg::FAIL_RANGE;
            end else if (status.at_or_above) begin
               if (status.cap_bad) begin
                  cmd.set_fail  = 1'b1;
                  cmd.fail_code = spsc_pkg::FAIL_CAPACITY;
               end else begin
                  state_in = ST_PUSH;
               end
            end else if (status.stack_empty) begin
               cmd.set_fail  = 1'b1;
               cmd.fail_code = spsc_pkg::FAIL_NOT_TOP;
            end else begin
               cmd.read_top = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_PUSH: begin
            // one skipped value per cycle; the popped value itself is not stored, the next push moves past it
            if (status.push_done) begin
               cmd.set_next = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.push = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.top_match) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.set_fail  = 1'b1;
               cmd.fail_code = spsc_pkg::FAIL_NOT_TOP;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.is_last) begin
               state_in = ST_IDLE;
            end else if (!rsp_busy) begin
               cmd.load_rsp  = 1'b1;
               cmd.clear_seq = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### src/stack_pop_sequence_checker.sv
// top level of the stack pop sequence checker
//
//   channel  direction  contents
//   req      in         popped_value, is_last
//   rsp      out        sequence_ok, fail_reason (only after a last request)
//   csr      in         write_en, index, wdata (capacity, max_value)
//
// a request at or above the next push first pushes each value skipped ahead of
// it; the stack memory takes one push per cycle.
// a pop of the top needs one registered memory read; a request that fails its
// first check, or follows a failure, skips both the pushes and the read.
// a new request is taken while a response waits; a last request holds only while
// the response register is full. reset clears the sequence, capacity 5, max 7.
module stack_pop_sequence_checker #(
   parameter int STACK_DEPTH = 1024,
   parameter int VALUE_BITS  = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   spsc_req_if.sink                         req,
   spsc_rsp_if.source                       rsp,
   input  logic                             csr_write_en,
   input  logic [spsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [spsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   `include "stack_pop_sequence_checker_defines.svh"

   spsc_pkg::spsc_cmd_type    cmd;
   spsc_pkg::spsc_status_type status;

   // control
   spsc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   spsc_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_value   (req.popped_value),
      .item_last    (req.is_last),
      .cmd          (cmd),
      .status       (status),
      .rsp_ok       (rsp.sequence_ok),
      .rsp_reason   (rsp.fail_reason)
   );

   // a response is never loaded over one still waiting
   `SPSC_ASSERT_IMPL(a_no_rsp_overwrite, clock, reset, cmd.load_rsp, !(rsp.valid && !rsp.ready), "response overwritten")
   // a request in work keeps the input closed
   `SPSC_ASSERT_NEXT(a_busy_after_load, clock, reset, cmd.load_item, !req.ready, "request taken while busy")
   // pushes run only within the checked room and range
   `SPSC_ASSERT_IMPL(a_push_in_room, clock, reset, cmd.push, status.at_or_above && !status.cap_bad && !status.range_bad, "push beyond checked room")

endmodule
